// File: design/first_match_ip_prefix_filter_core_defines.svh
// assertion macros used by the filter datapath rtl
`ifndef FIRST_MATCH_IP_PREFIX_FILTER_CORE_DEFINES_SVH
`define FIRST_MATCH_IP_PREFIX_FILTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every clock edge once reset is released
`define FMIPF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fmipf assertion failed");

// checked on every clock edge, reset included
`define FMIPF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fmipf assertion failed");

`else

`define FMIPF_ASSERT(label, prop)
`define FMIPF_ASSERT_ALWAYS(label, prop)

`endif

`endif

// File: design/fmipf_pkg.sv
// shared types, constants and helpers of the first-match prefix filter
package fmipf_pkg;

    localparam int MAX_RULES = 64;
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [5:0] PLEN_MAX = 6'd32;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [31:0] base;
        logic [5:0]  plen;
        logic        action;
    } rule_t;

    // controller to datapath
    typedef struct packed {
        logic add;
        logic clear;
        logic scan_start;
        logic scan_step;
        logic respond;
        logic verdict;
        logic full;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic hit_action;
        logic miss_end;
    } status_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        logic [31:0] ones;
        ones = '1;
        return ~(ones >> plen);
    endfunction

endpackage

// File: design/fmipf_ctrl.sv
// sequencing state machine of the prefix filter
module fmipf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           func,
    input  fmipf_pkg::status_t   status,
    output fmipf_pkg::cmd_t      cmd,
    output logic                 busy
);

    fmipf_pkg::state_t state_reg;
    fmipf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmipf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            fmipf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (func)
                        fmipf_pkg::FUNC_ADD:
                        begin
                            cmd.respond = 1'b1;
                            if (status.full)
                            begin
                                cmd.full = 1'b1;
                            end
                            else
                            begin
                                cmd.add = 1'b1;
                            end
                        end
                        fmipf_pkg::FUNC_QUERY:
                        begin
                            // empty table answers accept at once
                            if (status.empty)
                            begin
                                cmd.respond = 1'b1;
                                cmd.verdict = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = fmipf_pkg::ST_SCAN;
                            end
                        end
                        fmipf_pkg::FUNC_CLEAR:
                        begin
                            cmd.clear   = 1'b1;
                            cmd.respond = 1'b1;
                        end
                        default:
                        begin
                            cmd.respond = 1'b1;
                        end
                    endcase
                end
            end
            fmipf_pkg::ST_SCAN:
            begin
                busy          = 1'b1;
                cmd.scan_step = 1'b1;
                if (status.hit)
                begin
                    cmd.respond = 1'b1;
                    cmd.verdict = status.hit_action;
                    state_next  = fmipf_pkg::ST_IDLE;
                end
                else if (status.miss_end)
                begin
                    cmd.respond = 1'b1;
                    cmd.verdict = 1'b1;
                    state_next  = fmipf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmipf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/fmipf_dp.sv
// rule table, scan pointer, match compare and result registers
`include "first_match_ip_prefix_filter_core_defines.svh"

module fmipf_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          address,
    input  logic [5:0]           prefix_len,
    input  logic                 allow,
    input  fmipf_pkg::cmd_t      cmd,
    output fmipf_pkg::status_t   status,
    output logic                 done,
    output logic                 verdict,
    output logic                 table_full
);

    fmipf_pkg::rule_t mem [fmipf_pkg::MAX_RULES];
    fmipf_pkg::rule_t rd_data_reg;
    fmipf_pkg::rule_t wr_rule;

    logic [fmipf_pkg::CNT_W-1:0] count_reg, count_next;
    logic [fmipf_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                        issue_done_reg, issue_done_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic                        cmp_last_reg, cmp_last_next;
    logic [31:0]                 qaddr_reg;
    logic                        done_reg, verdict_reg, full_reg;

    logic        last_idx;
    logic [31:0] mask;
    logic        match;

    always_comb
    begin
        wr_rule.base   = address;
        wr_rule.plen   = (prefix_len > fmipf_pkg::PLEN_MAX) ? fmipf_pkg::PLEN_MAX : prefix_len;
        wr_rule.action = allow;
    end

    // rule table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            mem[count_reg[fmipf_pkg::IDX_W-1:0]] <= wr_rule;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            qaddr_reg <= address;
        end
    end

    assign last_idx = (fmipf_pkg::CNT_W'(idx_reg) == count_reg - fmipf_pkg::CNT_W'(1));
    assign mask     = fmipf_pkg::prefix_mask(rd_data_reg.plen);
    assign match    = ((qaddr_reg & mask) == (rd_data_reg.base & mask));

    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        cmp_valid_next  = 1'b0;
        cmp_last_next   = cmp_last_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.add)
        begin
            count_next = count_reg + fmipf_pkg::CNT_W'(1);
        end
        if (cmd.scan_start)
        begin
            idx_next        = '0;
            issue_done_next = 1'b0;
        end
        else if (cmd.scan_step && !issue_done_reg)
        begin
            // read data for idx_reg lands next cycle
            cmp_valid_next  = 1'b1;
            cmp_last_next   = last_idx;
            issue_done_next = last_idx;
            if (!last_idx)
            begin
                idx_next = idx_reg + fmipf_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            issue_done_reg <= 1'b1;
            cmp_valid_reg  <= 1'b0;
            cmp_last_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_last_reg   <= cmp_last_next;
            done_reg       <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= cmd.verdict;
        full_reg    <= cmd.full;
    end

    always_comb
    begin
        status.empty      = (count_reg == '0);
        status.full       = (count_reg == fmipf_pkg::CNT_W'(fmipf_pkg::MAX_RULES));
        status.hit        = cmp_valid_reg && match;
        status.hit_action = rd_data_reg.action;
        status.miss_end   = cmp_valid_reg && cmp_last_reg && !match;
    end

    assign done       = done_reg;
    assign verdict    = verdict_reg;
    assign table_full = full_reg;

    `FMIPF_ASSERT(a_count_bound, count_reg <= fmipf_pkg::CNT_W'(fmipf_pkg::MAX_RULES))
    `FMIPF_ASSERT(a_no_write_when_full, cmd.add |-> !status.full)
    `FMIPF_ASSERT(a_clear_empties, cmd.clear |=> count_reg == '0)
    `FMIPF_ASSERT(a_add_counts, cmd.add |=> count_reg == $past(count_reg) + fmipf_pkg::CNT_W'(1))
    `FMIPF_ASSERT_ALWAYS(a_hit_miss_excl, cmp_valid_reg |-> !(status.hit && status.miss_end))

endmodule

// File: design/first_match_ip_prefix_filter_core.sv
// top level of the first-match ipv4 prefix filter
//
//  channel  | beat marker      | payload
//  ---------+------------------+----------------------------------
//  command  | start & !busy    | func, address, prefix_len, allow
//  result   | done             | verdict, table_full
//
// add, clear and unused codes: result beat in the cycle after acceptance, busy stays low
// query: busy while rules are read in order up to the first match or the last rule,
// result beat as busy drops; a query on an empty table answers like an add
// worst case set by the one-read-per-cycle scan of a full rule table
// reset clears the rule count; table contents are left as they are
// results are presented for one cycle only, the receiver cannot stall them
module first_match_ip_prefix_filter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_len,
    input  logic        allow,
    output logic        done,
    output logic        verdict,
    output logic        table_full
);

    fmipf_pkg::cmd_t    cmd;
    fmipf_pkg::status_t status;

    fmipf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    fmipf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .address    (address),
        .prefix_len (prefix_len),
        .allow      (allow),
        .cmd        (cmd),
        .status     (status),
        .done       (done),
        .verdict    (verdict),
        .table_full (table_full)
    );

endmodule

// File: tb/tb_first_match_ip_prefix_filter_core.sv
// testbench for the first-match ipv4 prefix filter core
`timescale 1ns / 1ps

module tb_first_match_ip_prefix_filter_core;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         RANDOM_ITEMS = 1800;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] address;
        logic        verdict;
        logic        table_full;
    } filter_answer_t;

    // holds its own rule table and the answers still owed by the block
    class filter_scoreboard;
        fmipf_pkg::rule_t rules [fmipf_pkg::MAX_RULES];
        int unsigned      rule_count;
        filter_answer_t   owed [$];
        int unsigned      errors;
        int unsigned      n_add, n_refused, n_query, n_denied, n_clear, n_unused;

        function new();
            rule_count = 0;
            errors     = 0;
            n_add      = 0;
            n_refused  = 0;
            n_query    = 0;
            n_denied   = 0;
            n_clear    = 0;
            n_unused   = 0;
        endfunction

        function logic [31:0] network_mask(input logic [5:0] len);
            logic [63:0] wide;
            wide = 64'h0000_0000_FFFF_FFFF << (32 - len);
            return wide[31:0];
        endfunction

        function void note_command(input logic [1:0] f, input logic [31:0] a,
                                   input logic [5:0] p, input logic al);
            filter_answer_t ans;
            logic [5:0]     len;
            logic [31:0]    m;
            logic           found;
            len = (p > fmipf_pkg::PLEN_MAX) ? fmipf_pkg::PLEN_MAX : p;
            ans.func       = f;
            ans.address    = a;
            ans.verdict    = 1'b0;
            ans.table_full = 1'b0;
            case (f)
                fmipf_pkg::FUNC_ADD:
                begin
                    n_add++;
                    if (rule_count >= fmipf_pkg::MAX_RULES)
                    begin
                        ans.table_full = 1'b1;
                        n_refused++;
                    end
                    else
                    begin
                        rules[rule_count].base   = a;
                        rules[rule_count].plen   = len;
                        rules[rule_count].action = al;
                        rule_count++;
                    end
                end
                fmipf_pkg::FUNC_QUERY:
                begin
                    n_query++;
                    ans.verdict = 1'b1;
                    found = 1'b0;
                    for (int i = 0; i < rule_count; i++)
                    begin
                        m = network_mask(rules[i].plen);
                        if (!found && ((a & m) == (rules[i].base & m)))
                        begin
                            ans.verdict = rules[i].action;
                            found = 1'b1;
                        end
                    end
                    if (!ans.verdict)
                        n_denied++;
                end
                fmipf_pkg::FUNC_CLEAR:
                begin
                    n_clear++;
                    rule_count = 0;
                end
                default: n_unused++;
            endcase
            owed.push_back(ans);
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(input logic v, input logic full);
            filter_answer_t ans;
            if (owed.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing owed (verdict %b full %b)",
                                          v, full));
            end
            else
            begin
                ans = owed.pop_front();
                if (v !== ans.verdict)
                    report_mismatch($sformatf("func %0d addr %h: verdict %b, want %b",
                                              ans.func, ans.address, v, ans.verdict));
                if (full !== ans.table_full)
                    report_mismatch($sformatf("func %0d addr %h: table_full %b, want %b",
                                              ans.func, ans.address, full, ans.table_full));
            end
        endtask

        function int unsigned pending();
            return owed.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic        allow;
    logic        done;
    logic        verdict;
    logic        table_full;

    filter_scoreboard sb;
    int unsigned      idle_pct;
    logic [31:0]      stored_bases [$];

    first_match_ip_prefix_filter_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .address    (address),
        .prefix_len (prefix_len),
        .allow      (allow),
        .done       (done),
        .verdict    (verdict),
        .table_full (table_full)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(verdict, table_full);
    end

    // hold start high until the beat is taken, then maybe leave a gap
    task automatic send_command(input logic [1:0] f, input logic [31:0] a,
                                input logic [5:0] p, input logic al);
        func       <= f;
        address    <= a;
        prefix_len <= p;
        allow      <= al;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(f, a, p, al);
        if (f == fmipf_pkg::FUNC_ADD && stored_bases.size() < fmipf_pkg::MAX_RULES)
            stored_bases.push_back(a);
        if (f == fmipf_pkg::FUNC_CLEAR)
            stored_bases.delete();
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            // mostly short gaps, now and then a long one that can span a whole scan
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(5, fmipf_pkg::MAX_RULES + 4)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic logic [5:0] pick_prefix();
        if ($urandom_range(9) == 0)
            return 6'($urandom_range(33, 63));
        return 6'($urandom_range(0, 32));
    endfunction

    // an address near a stored base, so that queries hit rules deep in the table
    function automatic logic [31:0] pick_query_address();
        logic [63:0] low_bits;
        logic [31:0] base;
        if (stored_bases.size() == 0 || $urandom_range(4) == 0)
            return $urandom;
        base     = stored_bases[$urandom_range(stored_bases.size() - 1)];
        low_bits = (64'd1 << $urandom_range(0, 32)) - 64'd1;
        return base ^ ($urandom & low_bits[31:0]);
    endfunction

    initial
    begin
        int unsigned n_random;
        int unsigned n_adds;
        int unsigned n_queries;
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = fmipf_pkg::FUNC_ADD;
        address    = '0;
        prefix_len = '0;
        allow      = 1'b0;
        idle_pct   = 30;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every code, special cases
        send_command(FUNC_UNUSED, 32'hFFFF_FFFF, 6'h3F, 1'b1);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h0A01_0203, 6'd0, 1'b0);
        send_command(fmipf_pkg::FUNC_ADD, 32'h0A01_0203, 6'd32, 1'b0);
        send_command(fmipf_pkg::FUNC_ADD, 32'h0A01_0000, 6'd16, 1'b1);
        // host bits below the prefix are ignored
        send_command(fmipf_pkg::FUNC_ADD, 32'hC0A8_4DC8, 6'd24, 1'b1);
        // prefix beyond 32 acts as a single host
        send_command(fmipf_pkg::FUNC_ADD, 32'h0808_0808, 6'h3F, 1'b0);
        send_command(fmipf_pkg::FUNC_ADD, 32'hFFFF_FFFF, 6'd0, 1'b0);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h0A01_0203, 6'd0, 1'b1);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h0A01_C809, 6'd0, 1'b1);
        send_command(fmipf_pkg::FUNC_QUERY, 32'hC0A8_4D01, 6'd0, 1'b0);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h0808_0808, 6'd0, 1'b1);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h0808_0809, 6'd0, 1'b1);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h0000_0000, 6'h3F, 1'b1);
        send_command(fmipf_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 6'd0, 1'b0);
        send_command(fmipf_pkg::FUNC_CLEAR, 32'h1234_5678, 6'd7, 1'b1);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h0A01_0203, 6'd0, 1'b0);
        send_command(fmipf_pkg::FUNC_ADD, 32'h0000_0000, 6'd1, 1'b0);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h7FFF_FFFF, 6'd0, 1'b0);
        send_command(fmipf_pkg::FUNC_QUERY, 32'h8000_0000, 6'd0, 1'b0);
        send_command(FUNC_UNUSED, 32'h0000_0000, 6'd0, 1'b0);

        // random: mostly clear, add rules (now and then enough to fill the table), then query around them
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            idle_pct = (n_random >= 600 && n_random < 900) ? 0 : 30;
            if ($urandom_range(99) < 80)
            begin
                send_command(fmipf_pkg::FUNC_CLEAR, $urandom, 6'($urandom), 1'($urandom));
                n_random++;
            end
            if ($urandom_range(99) < 15)
                n_adds = $urandom_range(fmipf_pkg::MAX_RULES - 2, fmipf_pkg::MAX_RULES + 6);
            else
                n_adds = $urandom_range(0, 12);
            repeat (n_adds)
            begin
                send_command(fmipf_pkg::FUNC_ADD, $urandom, pick_prefix(), 1'($urandom));
                n_random++;
            end
            n_queries = $urandom_range(4, 20);
            repeat (n_queries)
            begin
                if ($urandom_range(99) < 4)
                    send_command(FUNC_UNUSED, $urandom, 6'($urandom), 1'($urandom));
                else
                    send_command(fmipf_pkg::FUNC_QUERY, pick_query_address(), 6'($urandom),
                                 1'($urandom));
                n_random++;
            end
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (fmipf_pkg::MAX_RULES + 8) @(posedge clk);

        $display("run covered %0d adds (%0d refused on a full table), %0d queries (%0d denied),",
                 sb.n_add, sb.n_refused, sb.n_query, sb.n_denied);
        $display("%0d clears and %0d unused codes, %0d mismatches",
                 sb.n_clear, sb.n_unused, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results still owed", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule
